// ===== rtl/core/polyphonic_adsr_tone_mixer_unit_macros.svh =====
// Assertion macros shared by the tone mixer RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef POLYPHONIC_ADSR_TONE_MIXER_UNIT_MACROS_SVH
`define POLYPHONIC_ADSR_TONE_MIXER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PATM_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PATM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PATM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PATM_ASSERT_HOLD(lbl, cond, msg)
`define PATM_ASSERT_IMPL(lbl, ante, cons, msg)
`define PATM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/patm_pkg.sv =====
// Shared types and constants of the tone mixer: note ROMs, sine polynomial,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package patm_pkg;

    localparam logic [5:0] NOTE_LAST = 6'd62;
    localparam logic [19:0] AGE_MAX = 20'hFFFFF;
    localparam int AMP_TAB_W = 21;
    localparam int AMP_W = 14;
    localparam int MB_W = 15;
    localparam logic [20:0] VOICE_GAIN = 21'd2200;
    localparam logic [63:0] RATE_MHZ = 64'd44100000;
    localparam logic [63:0] RATE_MHZ_HALF = 64'd22050000;

    localparam logic [14:0] SIN_A = 15'd25736;
    localparam logic [14:0] SIN_B = 15'd10512;
    localparam logic [14:0] SIN_C = 15'd1160;
    localparam logic [14:0] Z_ONE = 15'd16384;
    localparam logic [8:0] ENV_HOLD = 9'd256;
    localparam logic [8:0] ENV_PEAK = 9'd384;

    localparam logic MODE_TICK = 1'b1;

    // entry 63 mirrors entry 0
    localparam logic [19:0] NOTE_MHZ [64] = '{
        20'd27500, 20'd29135, 20'd30868, 20'd32703, 20'd34648, 20'd36708, 20'd38891,
        20'd41203, 20'd43654, 20'd46249, 20'd48999, 20'd51913, 20'd55000, 20'd58270,
        20'd61735, 20'd65406, 20'd69296, 20'd73416, 20'd77782, 20'd82407, 20'd87307,
        20'd92499, 20'd97999, 20'd103826, 20'd110000, 20'd116541, 20'd123471,
        20'd130813, 20'd138591, 20'd146832, 20'd155563, 20'd164814, 20'd174614,
        20'd184997, 20'd195998, 20'd207652, 20'd220000, 20'd233082, 20'd246942,
        20'd261626, 20'd277183, 20'd293665, 20'd311127, 20'd329628, 20'd349228,
        20'd369994, 20'd391995, 20'd415305, 20'd440000, 20'd466164, 20'd493883,
        20'd523251, 20'd554365, 20'd587330, 20'd622254, 20'd659255, 20'd698456,
        20'd739989, 20'd783991, 20'd830609, 20'd880000, 20'd932328, 20'd987767,
        20'd27500
    };

    localparam logic [8:0] NOTE_VOL [64] = '{
        9'd509, 9'd495, 9'd482, 9'd469, 9'd457, 9'd446, 9'd435, 9'd425, 9'd416, 9'd407,
        9'd398, 9'd390, 9'd383, 9'd376, 9'd369, 9'd363, 9'd357, 9'd351, 9'd346, 9'd341,
        9'd336, 9'd331, 9'd327, 9'd323, 9'd319, 9'd316, 9'd312, 9'd309, 9'd306, 9'd303,
        9'd301, 9'd298, 9'd296, 9'd294, 9'd292, 9'd290, 9'd288, 9'd286, 9'd284, 9'd283,
        9'd281, 9'd280, 9'd278, 9'd277, 9'd276, 9'd275, 9'd274, 9'd273, 9'd272, 9'd271,
        9'd270, 9'd269, 9'd269, 9'd268, 9'd267, 9'd267, 9'd266, 9'd265, 9'd265, 9'd264,
        9'd264, 9'd263, 9'd263, 9'd509
    };

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SILENT = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        MS_NONE = 3'd0,
        MS_AMP  = 3'd1,
        MS_ZZ   = 3'd2,
        MS_C    = 3'd3,
        MS_IN   = 3'd4,
        MS_PO   = 3'd5,
        MS_SA   = 3'd6,
        MS_TRI  = 3'd7
    } mul_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     trig_calc;
        logic     trig_write;
        logic     tick_start;
        logic     rd;
        logic     eval;
        logic     div_step;
        logic     amp_latch;
        mul_sel_t mul_sel;
        logic     acc;
        logic     next_voice;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic  is_tick;
        logic  active;
        logic  need_div;
        logic  div_done;
        logic  last_voice;
        wave_t wave;
        logic  out_room;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/polyphonic_adsr_tone_mixer_unit.sv =====
// Polyphonic ADSR tone mixer: top level, joins the sequencer and datapath.
// Depends on patm_pkg, patm_ctrl, patm_dp.
//
// Input stream s_*: tuser = mode (0 trigger, 1 tick). A trigger with note and slot in
// range loads that voice slot with shape, note and envelope times; no trigger gives an
// output beat. A tick mixes every voice and gives one output beat on m_*.
// Per voice, a tick reads the slot and evaluates its envelope region; an inactive voice is
// skipped, a silent one is only counted, and a sounding one runs the envelope divider if
// needed, then amplitude and sine or triangle products on the single shared multiplier.
// One item is worked at a time; s_tready is high only between items.
// The output register holds a finished beat while the next item is accepted;
// a tick that completes while that beat still stalls waits until it is taken.
// Reset clears all voice valid bits, so every voice starts silent and inactive;
// the voice memory itself needs no clearing pass.
// Output beat: m_tdata[15:0] mixed sample, [20:16] active count; m_tuser clipped.
`default_nettype none
module polyphonic_adsr_tone_mixer_unit #(
    parameter int VOICES = 20,
    parameter int PHASE_BITS = 24,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[4:0] shape[6:5] note[12:7] attack[24:13] decay[36:25]
    // sustain[48:37] release[60:49]
    input  logic [63:0] s_tdata,
    // mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mixed_sample[15:0] active_count[20:16]
    output logic [23:0] m_tdata,
    // clipped
    output logic        m_tuser
);
    import patm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    patm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    patm_dp #(
        .VOICES           (VOICES),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/core/patm_ctrl.sv =====
// Sequencer of the tone mixer: walks triggers and the per-voice tick loop.
// Depends on patm_pkg; drives patm_dp through dp_cmd_t.
`default_nettype none
module patm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  patm_pkg::dp_stat_t stat,
    output patm_pkg::dp_cmd_t  cmd
);
    import patm_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'b00000000000000001,
        ST_DECODE  = 17'b00000000000000010,
        ST_TCALC   = 17'b00000000000000100,
        ST_TWRITE  = 17'b00000000000001000,
        ST_RD      = 17'b00000000000010000,
        ST_EVAL    = 17'b00000000000100000,
        ST_DIV     = 17'b00000000001000000,
        ST_AMP     = 17'b00000000010000000,
        ST_AMPL    = 17'b00000000100000000,
        ST_SIN_ZZ  = 17'b00000001000000000,
        ST_SIN_C   = 17'b00000010000000000,
        ST_SIN_IN  = 17'b00000100000000000,
        ST_SIN_PO  = 17'b00001000000000000,
        ST_SIN_SA  = 17'b00010000000000000,
        ST_TRI     = 17'b00100000000000000,
        ST_ACC     = 17'b01000000000000000,
        ST_FIN     = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.mul_sel = MS_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_tick)
                begin
                    cmd.tick_start = 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_TCALC;
                end
            end
            ST_TCALC:
            begin
                cmd.trig_calc = 1'b1;
                state_next = ST_TWRITE;
            end
            ST_TWRITE:
            begin
                cmd.trig_write = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                cmd.rd = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!stat.active)
                begin
                    cmd.next_voice = 1'b1;
                    state_next = stat.last_voice ? ST_FIN : ST_RD;
                end
                else if (stat.wave == WAVE_SILENT)
                begin
                    state_next = ST_ACC;
                end
                else if (stat.need_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_AMP;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_AMP;
                end
            end
            ST_AMP:
            begin
                cmd.mul_sel = MS_AMP;
                state_next = ST_AMPL;
            end
            ST_AMPL:
            begin
                cmd.amp_latch = 1'b1;
                case (stat.wave)
                    WAVE_SINE: state_next = ST_SIN_ZZ;
                    WAVE_TRI:  state_next = ST_TRI;
                    default:   state_next = ST_ACC;
                endcase
            end
            ST_SIN_ZZ:
            begin
                cmd.mul_sel = MS_ZZ;
                state_next = ST_SIN_C;
            end
            ST_SIN_C:
            begin
                cmd.mul_sel = MS_C;
                state_next = ST_SIN_IN;
            end
            ST_SIN_IN:
            begin
                cmd.mul_sel = MS_IN;
                state_next = ST_SIN_PO;
            end
            ST_SIN_PO:
            begin
                cmd.mul_sel = MS_PO;
                state_next = ST_SIN_SA;
            end
            ST_SIN_SA:
            begin
                cmd.mul_sel = MS_SA;
                state_next = ST_ACC;
            end
            ST_TRI:
            begin
                cmd.mul_sel = MS_TRI;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                cmd.next_voice = 1'b1;
                state_next = stat.last_voice ? ST_FIN : ST_RD;
            end
            ST_FIN:
            begin
                if (stat.out_room)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/patm_dp.sv =====
// Datapath of the tone mixer: voice memory, envelope divider, shared
// multiplier, mix accumulator and output register. Depends on patm_pkg.
`default_nettype none
`include "polyphonic_adsr_tone_mixer_unit_macros.svh"
module patm_dp #(
    parameter int VOICES = 20,
    parameter int PHASE_BITS = 24,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [63:0]        s_tdata,
    input  logic               s_tuser,
    input  patm_pkg::dp_cmd_t  cmd,
    output patm_pkg::dp_stat_t stat,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [23:0]        m_tdata,
    output logic               m_tuser
);
    import patm_pkg::*;

    localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = ($clog2(VOICES + 1) < 5) ? 5 : $clog2(VOICES + 1);
    localparam int LOGD = $clog2(SINE_TABLE_DEPTH);
    localparam int MA_W = (PHASE_BITS + 1 > AMP_TAB_W) ? PHASE_BITS + 1 : AMP_TAB_W;
    localparam int PR_W = MA_W + MB_W;
    localparam int SUM_W = AMP_W + VI_W + 2;
    localparam int NUM_W = 29;
    localparam int DSH_W = 28;
    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS+2:0] FULL3 = {3'b001, {PHASE_BITS{1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    typedef struct packed {
        logic [1:0]            wave;
        logic [5:0]            pitch;
        logic [19:0]           age;
        logic [PHASE_BITS-1:0] phase;
        logic [19:0]           ae;
        logic [19:0]           de;
        logic [19:0]           he;
        logic [19:0]           re;
    } voice_t;

    function automatic logic [19:0] to_samples(input logic [13:0] ms);
        logic [29:0] t;
        t = 30'(ms) * 30'd52429;
        return 20'(20'(ms) * 20'd44) + 20'(t >> 19);
    endfunction

    // note tables, folded at elaboration
    logic [AMP_TAB_W-1:0]  amp_tab [64];
    logic [PHASE_BITS-1:0] inc_tab [64];
    for (genvar i = 0; i < 64; i++)
    begin : g_note
        assign amp_tab[i] = AMP_TAB_W'(21'(NOTE_VOL[i]) * VOICE_GAIN);
        assign inc_tab[i] = PHASE_BITS'(((64'(NOTE_MHZ[i]) << PHASE_BITS) + RATE_MHZ_HALF)
                                        / RATE_MHZ);
    end

    logic        in_mode_reg;
    logic [4:0]  in_slot_reg;
    logic [1:0]  in_wave_reg;
    logic [5:0]  in_note_reg;
    logic [11:0] in_ms_reg [4];
    logic [19:0] end_reg [4];

    voice_t mem [VOICES];
    voice_t rd_reg;
    voice_t mem_wd;
    logic   mem_we;
    logic [VI_W-1:0] mem_wa;

    logic [VOICES-1:0] valid_reg;
    logic              rd_valid_reg;
    logic [VI_W-1:0]   voice_idx_reg;

    logic [NUM_W-1:0] rem_reg, num;
    logic [DSH_W-1:0] dsh_reg;
    logic [19:0]      den;
    logic [8:0]       q_reg, env_base_reg, env_base;
    logic [3:0]       div_cnt_reg;
    logic [8:0]       env;

    logic [PR_W-1:0]  prod_reg;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [14:0]      p14, z2_reg;
    logic [AMP_W-1:0] amp_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        count_reg;

    logic        m_valid_reg, m_clip_reg;
    logic [15:0] m_sample_reg;
    logic [4:0]  m_count_reg;

    logic trig_ok, active, need_div, div_done;
    logic [19:0] dea, rea, dae, rhe;
    logic [LOGD-1:0] sidx;
    logic [15:0] ph16;
    logic [14:0] zraw, z;
    logic p_gt_half, tri_neg, c_neg;
    logic [PHASE_BITS:0] tri_d, tri_mag;
    logic [PHASE_BITS+2:0] four, tri_diff;
    logic [AMP_W-1:0] c_mag;
    logic [PHASE_BITS-1:0] p;

    // input capture and end points
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_mode_reg  <= s_tuser;
            in_slot_reg  <= s_tdata[4:0];
            in_wave_reg  <= s_tdata[6:5];
            in_note_reg  <= s_tdata[12:7];
            in_ms_reg[0] <= s_tdata[24:13];
            in_ms_reg[1] <= s_tdata[36:25];
            in_ms_reg[2] <= s_tdata[48:37];
            in_ms_reg[3] <= s_tdata[60:49];
        end
        if (cmd.trig_calc)
        begin
            end_reg[0] <= to_samples(14'(in_ms_reg[0]));
            end_reg[1] <= to_samples(14'(in_ms_reg[0]) + 14'(in_ms_reg[1]));
            end_reg[2] <= to_samples(14'(in_ms_reg[0]) + 14'(in_ms_reg[1])
                                     + 14'(in_ms_reg[2]));
            end_reg[3] <= to_samples(14'(in_ms_reg[0]) + 14'(in_ms_reg[1])
                                     + 14'(in_ms_reg[2]) + 14'(in_ms_reg[3]));
        end
    end

    assign trig_ok = (in_note_reg <= NOTE_LAST) && (7'(in_slot_reg) < 7'(VOICES));
    assign p = rd_reg.phase;

    // voice memory write: trigger load or tick write-back
    always_comb
    begin
        mem_we = (cmd.trig_write && trig_ok) || cmd.acc;
        mem_wa = cmd.acc ? voice_idx_reg : VI_W'(in_slot_reg);
        mem_wd = rd_reg;
        if (cmd.acc)
        begin
            mem_wd.age = (rd_reg.age < AGE_MAX) ? rd_reg.age + 20'd1 : rd_reg.age;
            mem_wd.phase = p + inc_tab[rd_reg.pitch];
        end
        else
        begin
            mem_wd.wave = in_wave_reg;
            mem_wd.pitch = in_note_reg;
            mem_wd.age = '0;
            mem_wd.phase = '0;
            mem_wd.ae = end_reg[0];
            mem_wd.de = end_reg[1];
            mem_wd.he = end_reg[2];
            mem_wd.re = end_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[voice_idx_reg];
        end
    end

    // envelope region
    always_comb
    begin
        dea = rd_reg.de - rd_reg.age;
        rea = rd_reg.re - rd_reg.age;
        dae = rd_reg.de - rd_reg.ae;
        rhe = rd_reg.re - rd_reg.he;
        active = rd_valid_reg && (rd_reg.age < rd_reg.re);
        if (rd_reg.age <= rd_reg.ae)
        begin
            need_div = (rd_reg.ae != '0);
            num = NUM_W'(rd_reg.age) * NUM_W'(ENV_PEAK);
            den = rd_reg.ae;
            env_base = '0;
        end
        else if (rd_reg.age <= rd_reg.de)
        begin
            need_div = 1'b1;
            num = NUM_W'(dea) << 7;
            den = dae;
            env_base = ENV_HOLD;
        end
        else if (rd_reg.age <= rd_reg.he)
        begin
            need_div = 1'b0;
            num = '0;
            den = '0;
            env_base = ENV_HOLD;
        end
        else
        begin
            need_div = 1'b1;
            num = NUM_W'(rea) << 8;
            den = rhe;
            env_base = '0;
        end
    end

    assign div_done = (div_cnt_reg == '0);
    assign env = env_base_reg + q_reg;

    // waveform geometry
    always_comb
    begin
        sidx = p[PHASE_BITS-1 -: LOGD];
        ph16 = 16'(sidx) << (16 - LOGD);
        zraw = {1'b0, ph16[13:0]};
        z = ph16[14] ? Z_ONE - zraw : zraw;
        p_gt_half = (p > HALF);
        tri_d = p_gt_half ? {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, p} : {1'b0, p};
        four = {tri_d, 2'b00};
        tri_neg = (four < FULL3);
        tri_diff = tri_neg ? FULL3 - four : four - FULL3;
        tri_mag = tri_diff[PHASE_BITS:0];
        p14 = prod_reg[28:14];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MS_AMP:
            begin
                mul_a = MA_W'(amp_tab[rd_reg.pitch]);
                mul_b = MB_W'(env);
            end
            MS_ZZ:
            begin
                mul_a = MA_W'(z);
                mul_b = z;
            end
            MS_C:
            begin
                mul_a = MA_W'(p14);
                mul_b = SIN_C;
            end
            MS_IN:
            begin
                mul_a = MA_W'(z2_reg);
                mul_b = SIN_B - p14;
            end
            MS_PO:
            begin
                mul_a = MA_W'(z);
                mul_b = SIN_A - p14;
            end
            MS_SA:
            begin
                mul_a = MA_W'(amp_reg);
                mul_b = p14;
            end
            MS_TRI:
            begin
                mul_a = MA_W'(tri_mag);
                mul_b = MB_W'(amp_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (wave_t'(rd_reg.wave))
            WAVE_SINE:
            begin
                c_mag = prod_reg[14 +: AMP_W];
                c_neg = ph16[15];
            end
            WAVE_SQUARE:
            begin
                c_mag = amp_reg;
                c_neg = !p_gt_half;
            end
            WAVE_TRI:
            begin
                c_mag = prod_reg[PHASE_BITS +: AMP_W];
                c_neg = tri_neg;
            end
            default:
            begin
                c_mag = '0;
                c_neg = 1'b0;
            end
        endcase
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            rem_reg <= num;
            dsh_reg <= {den, 8'b0};
            q_reg <= '0;
            env_base_reg <= env_base;
            div_cnt_reg <= 4'd8;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= NUM_W'(dsh_reg))
            begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
                q_reg <= {q_reg[7:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[7:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
            div_cnt_reg <= div_cnt_reg - 4'd1;
        end
        if (cmd.mul_sel != MS_NONE)
        begin
            prod_reg <= PR_W'(mul_a) * PR_W'(mul_b);
        end
        if (cmd.mul_sel == MS_C)
        begin
            z2_reg <= p14;
        end
        if (cmd.amp_latch)
        begin
            amp_reg <= prod_reg[16 +: AMP_W];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            voice_idx_reg <= '0;
            sum_reg <= '0;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
            m_clip_reg <= 1'b0;
            m_sample_reg <= '0;
            m_count_reg <= '0;
        end
        else
        begin
            if (cmd.trig_write && trig_ok)
            begin
                valid_reg[VI_W'(in_slot_reg)] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[voice_idx_reg];
            end
            if (cmd.tick_start)
            begin
                voice_idx_reg <= '0;
                sum_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.next_voice)
                begin
                    voice_idx_reg <= voice_idx_reg + VI_W'(1);
                end
                if (cmd.acc)
                begin
                    sum_reg <= c_neg ? sum_reg - SUM_W'(c_mag) : sum_reg + SUM_W'(c_mag);
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
                m_count_reg <= count_reg[4:0];
                if (sum_reg > SAT_HI)
                begin
                    m_sample_reg <= 16'h7FFF;
                    m_clip_reg <= 1'b1;
                end
                else if (sum_reg < SAT_LO)
                begin
                    m_sample_reg <= 16'h8000;
                    m_clip_reg <= 1'b1;
                end
                else
                begin
                    m_sample_reg <= sum_reg[15:0];
                    m_clip_reg <= 1'b0;
                end
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.is_tick = (in_mode_reg == MODE_TICK);
        stat.active = active;
        stat.need_div = need_div;
        stat.div_done = div_done;
        stat.last_voice = (voice_idx_reg == VI_W'(VOICES - 1));
        stat.wave = wave_t'(rd_reg.wave);
        stat.out_room = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {3'b000, m_count_reg, m_sample_reg};
    assign m_tuser = m_clip_reg;

    `PATM_ASSERT_IMPL(a_no_overrun, cmd.out_load, !m_valid_reg || m_tready, "result overrun")
    `PATM_ASSERT_NEXT(a_tick_clear, cmd.tick_start, (count_reg == '0) && (sum_reg == '0), "tick not cleared")
    `PATM_ASSERT_NEXT(a_env_range, cmd.div_step && div_done, env <= ENV_PEAK, "envelope above peak")
    `PATM_ASSERT_HOLD(a_count_bound, count_reg <= CNT_W'(VOICES), "voice count overflow")

endmodule
`default_nettype wire

// ===== tb/sv/polyphonic_adsr_tone_mixer_unit_tb.sv =====
// Self-checking bench for the polyphonic ADSR tone mixer: triggers and ticks go in,
// mixed samples come out and are compared with a local voice/envelope predictor.
// Depends on patm_pkg and polyphonic_adsr_tone_mixer_unit.
module polyphonic_adsr_tone_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import patm_pkg::*;

    localparam int NV = 20;
    localparam int PB = 24;
    localparam int SD = 256;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] mix;
        logic        clip;
        logic [4:0]  count;
    } mix_beat_t;

    class mix_scoreboard;
        int          sine_q14 [SD];
        wave_t       shape [NV];
        logic [5:0]  pitch [NV];
        logic [19:0] age [NV];
        logic [PB-1:0] phase [NV];
        logic [19:0] att_end [NV];
        logic [19:0] dec_end [NV];
        logic [19:0] hld_end [NV];
        logic [19:0] rel_end [NV];
        mix_beat_t   pending [$];
        int          errors;
        int          checked;
        int          clips;

        function new();
            longint unsigned ph, q, z, z2, inner, poly, s;
            for (int i = 0; i < SD; i++)
            begin
                ph = (longint'(i) << 16) / SD;
                q = (ph >> 14) & 3;
                z = ph & 16'h3FFF;
                if (q[0])
                    z = 16384 - z;
                z2 = (z * z) >> 14;
                inner = SIN_B - ((z2 * SIN_C) >> 14);
                poly = SIN_A - ((z2 * inner) >> 14);
                s = (z * poly) >> 14;
                sine_q14[i] = (q >= 2) ? -int'(s) : int'(s);
            end
            for (int v = 0; v < NV; v++)
            begin
                shape[v] = WAVE_SINE; pitch[v] = 0; age[v] = 0; phase[v] = 0;
                att_end[v] = 0; dec_end[v] = 0; hld_end[v] = 0; rel_end[v] = 0;
            end
            errors = 0;
            checked = 0;
            clips = 0;
        endfunction

        function logic [19:0] ms_samples(longint unsigned ms);
            return 20'((ms * 441) / 10);
        endfunction

        function longint unsigned env_q8(int v);
            longint unsigned a, ae, de, he, re;
            a = age[v]; ae = att_end[v]; de = dec_end[v]; he = hld_end[v]; re = rel_end[v];
            if (a <= ae)
                return (ae == 0) ? 0 : (384 * a) / ae;
            if (a <= de)
                return 256 + (128 * (de - a)) / (de - ae);
            if (a <= he)
                return 256;
            if (re <= he || a >= re)
                return 0;
            return (256 * (re - a)) / (re - he);
        endfunction

        function void note_input(logic mode, logic [63:0] d);
            longint unsigned a, dc, su, rl, p, amp, inc, mag, dd, four, full;
            longint signed sum;
            int slot, cnt, s;
            logic [5:0] note;
            mix_beat_t b;
            if (mode != MODE_TICK)
            begin
                slot = d[4:0];
                note = d[12:7];
                if (note > NOTE_LAST || slot >= NV)
                    return;
                a = d[24:13]; dc = d[36:25]; su = d[48:37]; rl = d[60:49];
                shape[slot] = wave_t'(d[6:5]);
                pitch[slot] = note;
                age[slot] = 0;
                phase[slot] = 0;
                att_end[slot] = ms_samples(a);
                dec_end[slot] = ms_samples(a + dc);
                hld_end[slot] = ms_samples(a + dc + su);
                rel_end[slot] = ms_samples(a + dc + su + rl);
                return;
            end
            sum = 0;
            cnt = 0;
            full = 64'd1 << PB;
            for (int v = 0; v < NV; v++)
            begin
                if (age[v] >= rel_end[v])
                    continue;
                cnt++;
                p = phase[v];
                amp = (longint'(NOTE_VOL[pitch[v]]) * 2200 * env_q8(v)) >> 16;
                case (shape[v])
                    WAVE_SINE:
                    begin
                        s = sine_q14[(p * SD) >> PB];
                        mag = (s < 0) ? -s : s;
                        if (s < 0)
                            sum -= (amp * mag) >> 14;
                        else
                            sum += (amp * mag) >> 14;
                    end
                    WAVE_SQUARE:
                        sum += (p > full / 2) ? amp : -longint'(amp);
                    WAVE_TRI:
                    begin
                        dd = (p > full / 2) ? full - p : p;
                        four = 4 * dd;
                        if (four < full)
                            sum -= ((full - four) * amp) >> PB;
                        else
                            sum += ((four - full) * amp) >> PB;
                    end
                    default: ;
                endcase
                inc = ((longint'(NOTE_MHZ[pitch[v]]) << PB) + 22050000) / 44100000;
                phase[v] = PB'(p + inc);
                if (age[v] != AGE_MAX)
                    age[v]++;
            end
            b.clip = 1'b0;
            if (sum > 32767)
            begin
                sum = 32767; b.clip = 1'b1;
            end
            else if (sum < -32768)
            begin
                sum = -32768; b.clip = 1'b1;
            end
            b.mix = 16'(sum);
            b.count = 5'(cnt);
            pending.push_back(b);
        endfunction

        task check_beat(logic [23:0] d, logic u);
            mix_beat_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("output beat with nothing expected", 0, d);
                return;
            end
            e = pending.pop_front();
            if (e.clip) clips++;
            if (d[15:0] !== e.mix)
                report_mismatch("mixed_sample", e.mix, d[15:0]);
            if (d[20:16] !== e.count)
                report_mismatch("active_count", e.count, d[20:16]);
            if (u !== e.clip)
                report_mismatch("clipped", e.clip, u);
        endtask

        task report_mismatch(string what, longint unsigned exp_v, longint unsigned got);
            errors++;
            if (errors <= 40)
                $display("MISMATCH beat %0d %s: expected %0h got %0h", checked, what, exp_v, got);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    mix_scoreboard sb;
    int  idle_cycles;
    bit  long_hold;
    bit  stim_done;
    int  ticks_sent;

    polyphonic_adsr_tone_mixer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // input beat bookkeeping, output checks and the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (stim_done && sb.pending.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("polyphonic_adsr_tone_mixer_unit_tb failed");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    initial
    begin
        int k;
        k = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            k++;
            if (long_hold)
                m_tready <= 1'b0;
            else if ((k / 300) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_beat(input logic mode, input logic [63:0] d);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic rest(input int n);
        s_tvalid <= 1'b0;
        s_tdata <= {$urandom, $urandom};
        s_tuser <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [63:0] pack_trigger(int slot, wave_t w, int note,
                                                 int a, int d, int s, int r);
        logic [63:0] t;
        t = '0;
        t[4:0] = 5'(slot); t[6:5] = w; t[12:7] = 6'(note);
        t[24:13] = 12'(a); t[36:25] = 12'(d); t[48:37] = 12'(s); t[60:49] = 12'(r);
        t[63:61] = 3'($urandom);
        return t;
    endfunction

    task automatic send_trigger(int slot, wave_t w, int note, int a, int d, int s, int r);
        send_beat(1'b0, pack_trigger(slot, w, note, a, d, s, r));
    endtask

    task automatic send_tick();
        send_beat(MODE_TICK, {$urandom, $urandom});
        ticks_sent++;
    endtask

    // mostly short envelopes; one trigger in 20 is drawn full-range
    task automatic random_trigger();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            send_trigger($urandom_range(0, 31), wave_t'($urandom_range(0, 3)),
                         $urandom_range(0, 63), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095));
        else
            send_trigger($urandom_range(0, 19), wave_t'($urandom_range(0, 3)),
                         $urandom_range(0, 62), $urandom_range(0, 1),
                         $urandom_range(0, 2), $urandom_range(0, 1),
                         $urandom_range(0, 2));
    endtask

    initial
    begin
        int gap;
        int burst;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        idle_cycles = 0;
        long_hold = 1'b0;
        stim_done = 1'b0;
        ticks_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every shape, ignored triggers, zero attack
        send_tick();
        send_trigger(0, WAVE_SINE, 0, 0, 0, 0, 1);
        send_trigger(1, WAVE_SQUARE, 62, 1, 1, 1, 1);
        send_trigger(2, WAVE_TRI, 30, 0, 1, 0, 1);
        send_trigger(3, WAVE_SILENT, 10, 1, 0, 1, 0);
        send_trigger(19, WAVE_SINE, 48, 4095, 4095, 4095, 4095);
        send_trigger(4, WAVE_SQUARE, 63, 1, 1, 1, 1);
        send_trigger(20, WAVE_TRI, 5, 1, 1, 1, 1);
        send_trigger(31, WAVE_SILENT, 63, 4095, 4095, 4095, 4095);
        repeat (6) send_tick();
        for (int v = 0; v < 20; v++)
            send_trigger(v, WAVE_SQUARE, 0, 0, 1, 1, 1);
        repeat (4) send_tick();

        // long receiver hold-off while ticks keep coming
        long_hold = 1'b1;
        fork
            repeat (12) send_tick();
            begin
                repeat (2000) @(posedge clk);
                long_hold = 1'b0;
            end
        join
        long_hold = 1'b0;

        // pause until drained
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        for (int n = 0; n < 470; )
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++, n++)
            begin
                if ($urandom_range(0, 2) == 0)
                    random_trigger();
                else
                    send_tick();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
            if (gap != 0)
                rest(gap);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("ran %0d ticks with triggers of all shapes and notes; %0d samples clipped",
                 ticks_sent, sb.clips);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("polyphonic_adsr_tone_mixer_unit_tb passed");
        else
            $display("polyphonic_adsr_tone_mixer_unit_tb failed");
        $finish;
    end
endmodule
